/* design/acpr_pkg.sv */
// Shared constants, result record and digit weight table for the packet reassembler.
`default_nettype none

package acpr_pkg;

  // Parameter defaults
  localparam int PAYLOAD_STRIDE_DEF      = 502;
  localparam int MAX_PACKET_BYTES_DEF    = 1024;
  localparam int BUFFER_ADDRESS_BITS_DEF = 20;

  // Fixed packet layout
  localparam int HEADER_BYTES = 10;
  localparam int CKS_DIGITS   = 6;
  localparam int DIGIT_BASE   = 48;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 10;
  localparam int WT_W    = 17;
  localparam int CKS_W   = 26;
  localparam int SEQ_W   = 19;
  localparam int BSUM_W  = 19;
  localparam int ADDR_W  = 20;

  // Stream widths
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 4;

  typedef struct packed {
    logic                    we;
    logic [ADDR_W-1:0]       waddr;
    logic [BYTE_W-1:0]       wdata;
    logic                    aerr;
    logic                    done;
    logic                    ok;
    logic                    shrt;
    logic signed [SEQ_W-1:0] seq;
  } acpr_result_t;

  // Decimal weight of each header digit, by byte position.
  function automatic logic [WT_W-1:0] digit_weight(input logic [3:0] idx);
    logic [WT_W-1:0] w;
    case (idx)
      4'd0:    w = WT_W'(100000);
      4'd1:    w = WT_W'(10000);
      4'd2:    w = WT_W'(1000);
      4'd3:    w = WT_W'(100);
      4'd4:    w = WT_W'(10);
      4'd5:    w = WT_W'(1);
      4'd6:    w = WT_W'(1000);
      4'd7:    w = WT_W'(100);
      4'd8:    w = WT_W'(10);
      4'd9:    w = WT_W'(1);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* design/acpr_core.sv */
// Per-packet accumulators and the result logic for one received byte.
`default_nettype none

module acpr_core #(
  parameter int PAYLOAD_STRIDE      = acpr_pkg::PAYLOAD_STRIDE_DEF,
  parameter int MAX_PACKET_BYTES    = acpr_pkg::MAX_PACKET_BYTES_DEF,
  parameter int BUFFER_ADDRESS_BITS = acpr_pkg::BUFFER_ADDRESS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  input  logic                   last_byte,
  output acpr_pkg::acpr_result_t res
);
  import acpr_pkg::*;

  localparam int POS_W  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int SW     = $clog2(PAYLOAD_STRIDE + 1);
  localparam int BASE_W = SEQ_W + SW + 1;
  localparam int BW_W   = $clog2(1000 * PAYLOAD_STRIDE + 1);
  localparam int PROD_W = DIGIT_W + BW_W + 1;
  localparam int SUM_W  = ((BASE_W > BUFFER_ADDRESS_BITS + 1) ? BASE_W
                                                               : BUFFER_ADDRESS_BITS + 1) + 1;

  // Sequence digit weights pre-scaled by the stride, so the base address
  // builds up alongside the sequence number.
  localparam logic [BW_W-1:0] BASE_WT [4] = '{
    BW_W'(1000 * PAYLOAD_STRIDE), BW_W'(100 * PAYLOAD_STRIDE),
    BW_W'(10 * PAYLOAD_STRIDE),   BW_W'(PAYLOAD_STRIDE)
  };
  localparam logic signed [SUM_W-1:0] ADDR_LIMIT =
    SUM_W'(longint'(1) << BUFFER_ADDRESS_BITS);

  logic [POS_W-1:0]         pos_r,  pos_nxt;
  logic signed [CKS_W-1:0]  cks_r,  cks_nxt;
  logic signed [SEQ_W-1:0]  seq_r,  seq_nxt;
  logic signed [BSUM_W-1:0] sum_r,  sum_nxt;
  logic signed [BASE_W-1:0] base_r, base_nxt;

  logic                     in_range, is_cks, is_seq, is_pay, addr_bad, shrt;
  logic signed [DIGIT_W-1:0] digit;
  logic [WT_W-1:0]          wt;
  logic signed [27:0]       dig_prod;
  logic [1:0]               seq_idx;
  logic signed [PROD_W-1:0] base_prod;
  logic [POS_W-1:0]         offset;
  logic signed [SUM_W-1:0]  addr;

  always_comb begin
    in_range = pos_r < POS_W'(MAX_PACKET_BYTES);
    is_cks   = pos_r < POS_W'(CKS_DIGITS);
    is_seq   = !is_cks && (pos_r < POS_W'(HEADER_BYTES));
    is_pay   = in_range && !is_cks && !is_seq;

    digit     = $signed({2'b00, rx_byte} - DIGIT_W'(DIGIT_BASE));
    wt        = digit_weight(pos_r[3:0]);
    dig_prod  = digit * $signed({1'b0, wt});
    seq_idx   = 2'(pos_r[3:0] - 4'd6);
    base_prod = digit * $signed({1'b0, BASE_WT[seq_idx]});

    offset   = pos_r - POS_W'(HEADER_BYTES);
    addr     = SUM_W'(base_r) + SUM_W'($signed({1'b0, offset}));
    addr_bad = addr[SUM_W-1] || (addr >= ADDR_LIMIT);
    shrt     = pos_r < POS_W'(HEADER_BYTES - 1);

    pos_nxt  = pos_r;
    cks_nxt  = cks_r;
    seq_nxt  = seq_r;
    sum_nxt  = sum_r;
    base_nxt = base_r;
    if (in_range) begin
      pos_nxt = pos_r + POS_W'(1);
      if (is_cks) begin
        cks_nxt = cks_r + CKS_W'(dig_prod);
      end else begin
        sum_nxt = sum_r + BSUM_W'($signed(rx_byte));
        if (is_seq) begin
          seq_nxt  = seq_r + SEQ_W'(dig_prod);
          base_nxt = base_r + BASE_W'(base_prod);
        end
      end
    end

    res = '0;
    if (is_pay) begin
      if (addr_bad) begin
        res.aerr = 1'b1;
      end else begin
        res.we    = 1'b1;
        res.waddr = addr[ADDR_W-1:0];
        res.wdata = rx_byte;
      end
    end
    if (last_byte) begin
      res.done = 1'b1;
      res.shrt = shrt;
      if (!shrt) begin
        // checksum digits are complete once the packet is not short
        res.ok  = (cks_r == CKS_W'(sum_nxt));
        res.seq = seq_nxt;
      end
      pos_nxt  = '0;
      cks_nxt  = '0;
      seq_nxt  = '0;
      sum_nxt  = '0;
      base_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      cks_r  <= '0;
      seq_r  <= '0;
      sum_r  <= '0;
      base_r <= '0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      cks_r  <= cks_nxt;
      seq_r  <= seq_nxt;
      sum_r  <= sum_nxt;
      base_r <= base_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/ascii_checksum_packet_reassembler.sv */
// Top level: input register, byte processing core and output register.
// The result of a byte is computed as it leaves the input register and is held in the output register.
// Throughput: one byte per cycle; the input register and the output register
// each advance every cycle unless the downstream side stalls.
// Reset: synchronous, active low; clears both stage valids and the packet
// accumulators, so the next byte is taken as position 0 of a new packet.
`default_nettype none

module ascii_checksum_packet_reassembler #(
  parameter int PAYLOAD_STRIDE      = acpr_pkg::PAYLOAD_STRIDE_DEF,
  parameter int MAX_PACKET_BYTES    = acpr_pkg::MAX_PACKET_BYTES_DEF,
  parameter int BUFFER_ADDRESS_BITS = acpr_pkg::BUFFER_ADDRESS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // rx_byte
  input  logic                            in_tlast,   // last_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // write_address[19:0], write_data[27:20], sequence_number[46:28], zero[47]
  output logic [acpr_pkg::OUT_DATA_W-1:0] out_tdata,
  // write_enable[0], address_error[1], checksum_ok[2], short_packet[3]
  output logic [acpr_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                            out_tlast   // packet_done
);
  import acpr_pkg::*;

  logic                  s1_valid_r;
  logic [BYTE_W-1:0]     s1_byte_r;
  logic                  s1_last_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic                  out_last_r;
  logic                  adv, in_acc;
  acpr_result_t          res;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  acpr_core #(
    .PAYLOAD_STRIDE      (PAYLOAD_STRIDE),
    .MAX_PACKET_BYTES    (MAX_PACKET_BYTES),
    .BUFFER_ADDRESS_BITS (BUFFER_ADDRESS_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .rx_byte   (s1_byte_r),
    .last_byte (s1_last_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (adv) begin
      out_data_r <= {1'b0, res.seq, res.wdata, res.waddr};
      out_user_r <= {res.shrt, res.ok, res.aerr, res.we};
      out_last_r <= res.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* design/acpr_checker.sv */
// Port-level checks on the reassembler's result stream, bound to the top level.
`default_nettype none

module acpr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [acpr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [acpr_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                            out_tlast
);

  // stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a write and an address error never come together
  a_we_aerr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("write and address error together");

  // no write: address and data are zero
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[27:0] == 28'd0)
    else $error("address or data set without write");

  // status only on the last byte; short packet has no checksum or sequence
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (!out_tlast || out_tuser[3]) |->
      !out_tuser[2] && out_tdata[46:28] == 19'd0)
    else $error("status set outside a complete packet end");

endmodule

bind ascii_checksum_packet_reassembler acpr_checker u_acpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
